// ----- hw/rtl/gdr_pkg.sv -----
// Shared types, constants and helper functions of the grid raycaster.
package gdr_pkg;

   localparam int DIVIDEND_W = 48;
   localparam int DIVISOR_W = 26;
   localparam logic [23:0] SAT24 = 24'hFFFFFF;
   localparam logic [16:0] LH_CAP = 17'h1FFFF;

   localparam logic [2:0] REG_POS_X = 3'd0;
   localparam logic [2:0] REG_POS_Y = 3'd1;
   localparam logic [2:0] REG_DIR_X = 3'd2;
   localparam logic [2:0] REG_DIR_Y = 3'd3;
   localparam logic [2:0] REG_PLANE_X = 3'd4;
   localparam logic [2:0] REG_PLANE_Y = 3'd5;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_CAST = 1'b1;

   typedef struct packed {
      logic [20:0] pos_x;
      logic [20:0] pos_y;
      logic signed [17:0] dir_x;
      logic signed [17:0] dir_y;
      logic signed [17:0] plane_x;
      logic signed [17:0] plane_y;
   } cfg_type;

   typedef struct packed {
      logic operation;
      logic [9:0] screen_column;
      logic [4:0] cell_x;
      logic [4:0] cell_y;
      logic [3:0] cell_value;
   } item_type;

   typedef struct packed {
      logic valid;
      item_type item;
   } head_type;

   typedef enum logic [4:0] {
      S_IDLE, S_CAMS, S_CAMW, S_MRX, S_MRY, S_RY, S_DXS, S_DXW, S_DYS, S_DYW,
      S_FX, S_FY, S_FYW, S_STEP, S_CHK, S_TEST, S_PRS, S_PRW, S_LHS, S_LHW,
      S_TEX1, S_TEX2
   } state_type;

   function automatic logic [25:0] abs26(input logic signed [25:0] v);
      abs26 = v[25] ? 26'(-v) : 26'(v);
   endfunction

   function automatic logic [23:0] sat24(input logic [47:0] v);
      sat24 = (v > 48'(SAT24)) ? SAT24 : v[23:0];
   endfunction

   function automatic logic [15:0] clamp16(input logic signed [18:0] v);
      if (v > 19'sd32767) begin
         clamp16 = 16'h7FFF;
      end else if (v < -19'sd32768) begin
         clamp16 = 16'h8000;
      end else begin
         clamp16 = v[15:0];
      end
   endfunction

endpackage

// ----- hw/rtl/grid_dda_raycaster_core.sv -----
// Top level of the grid raycaster: configuration registers, front queue and back end.
//
//   channel   ports            transfer
//   request   start, busy      taken when start is high and busy is low
//   response  rsp_strobe       one cycle per result, cannot be held off
//   config    csr_*            written when csr_write_enable is high
//
// A map write is done by the back end while it is idle. A cast uses the bit-serial divider
// for four divisions and walks the grid cell by cell. A two-item queue takes requests while
// a cast runs. Reset is synchronous and restores the default view; the map is undefined
// until written.
module grid_dda_raycaster_core #(
   parameter int MAP_DIM = 32,
   parameter int SCREEN_WIDTH = 1024,
   parameter int SCREEN_HEIGHT = 512,
   parameter int TEX_SIZE = 64,
   parameter int ATLAS_COLS = 4
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  logic req_operation,
   input  logic [9:0] req_screen_column,
   input  logic [4:0] req_cell_x,
   input  logic [4:0] req_cell_y,
   input  logic [3:0] req_cell_value,
   output logic rsp_strobe,
   output logic [9:0] rsp_result_column,
   output logic rsp_hit,
   output logic [3:0] rsp_tile,
   output logic rsp_side,
   output logic [23:0] rsp_perp_dist,
   output logic signed [15:0] rsp_draw_start,
   output logic signed [15:0] rsp_draw_end,
   output logic [5:0] rsp_tex_x,
   output logic [11:0] rsp_tex_base_x,
   output logic [11:0] rsp_tex_base_y,
   input  logic csr_write_enable,
   input  logic [2:0] csr_index,
   input  logic [20:0] csr_write_data
);
   import gdr_pkg::*;

   cfg_type cfg_ff;
   item_type req_item;
   head_type head;
   logic pop;

   assign req_item = '{operation: req_operation, screen_column: req_screen_column,
                       cell_x: req_cell_x, cell_y: req_cell_y, cell_value: req_cell_value};

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pos_x <= 21'd163840;
         cfg_ff.pos_y <= 21'd163840;
         cfg_ff.dir_x <= 18'sd0;
         cfg_ff.dir_y <= 18'sd65536;
         cfg_ff.plane_x <= -18'sd43254;
         cfg_ff.plane_y <= 18'sd0;
      end else if (csr_write_enable) begin
         case (csr_index)
            REG_POS_X: cfg_ff.pos_x <= csr_write_data;
            REG_POS_Y: cfg_ff.pos_y <= csr_write_data;
            REG_DIR_X: cfg_ff.dir_x <= csr_write_data[17:0];
            REG_DIR_Y: cfg_ff.dir_y <= csr_write_data[17:0];
            REG_PLANE_X: cfg_ff.plane_x <= csr_write_data[17:0];
            REG_PLANE_Y: cfg_ff.plane_y <= csr_write_data[17:0];
            default: cfg_ff <= cfg_ff;
         endcase
      end
   end

   gdr_front u_front (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .item(req_item), .pop(pop), .head(head)
   );

   gdr_back #(
      .MAP_DIM(MAP_DIM), .SCREEN_WIDTH(SCREEN_WIDTH), .SCREEN_HEIGHT(SCREEN_HEIGHT),
      .TEX_SIZE(TEX_SIZE), .ATLAS_COLS(ATLAS_COLS)
   ) u_back (
      .clock(clock), .reset(reset), .head(head), .pop(pop), .cfg(cfg_ff),
      .rsp_strobe(rsp_strobe), .rsp_result_column(rsp_result_column), .rsp_hit(rsp_hit),
      .rsp_tile(rsp_tile), .rsp_side(rsp_side), .rsp_perp_dist(rsp_perp_dist),
      .rsp_draw_start(rsp_draw_start), .rsp_draw_end(rsp_draw_end), .rsp_tex_x(rsp_tex_x),
      .rsp_tex_base_x(rsp_tex_base_x), .rsp_tex_base_y(rsp_tex_base_y)
   );

endmodule

// ----- hw/rtl/gdr_front.sv -----
// Front end: accepts items into a two-entry queue ahead of the sequencer.
module gdr_front (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  gdr_pkg::item_type item,
   input  logic pop,
   output gdr_pkg::head_type head
);
   import gdr_pkg::*;

   item_type slot_ff [2];
   logic wr_ptr_ff, wr_ptr_in;
   logic rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic push;

   assign busy = (count_ff == 2'd2);
   assign push = start && !busy;
   assign head.valid = (count_ff != 2'd0);
   assign head.item = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = (pop && head.valid) ? !rd_ptr_ff : rd_ptr_ff;
      count_in = count_ff + 2'(push) - 2'(pop && head.valid);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= item;
      end
   end

endmodule

// ----- hw/rtl/gdr_div.sv -----
// Bit-serial restoring divider, one quotient bit per cycle.
module gdr_div (
   input  logic clock,
   input  logic reset,
   input  logic go,
   input  logic [gdr_pkg::DIVIDEND_W-1:0] dividend,
   input  logic [gdr_pkg::DIVISOR_W-1:0] divisor,
   output logic done,
   output logic [gdr_pkg::DIVIDEND_W-1:0] quotient
);
   import gdr_pkg::*;

   logic running_ff, done_ff;
   logic [5:0] cnt_ff;
   logic [DIVISOR_W-1:0] rem_ff, dsr_ff;
   logic [DIVIDEND_W-1:0] q_ff;
   logic [DIVISOR_W:0] shifted;
   logic take;

   assign shifted = {rem_ff, q_ff[DIVIDEND_W-1]};
   assign take = (shifted >= {1'b0, dsr_ff});
   assign done = done_ff;
   assign quotient = q_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= 6'd0;
      end else begin
         done_ff <= running_ff && (cnt_ff == 6'(DIVIDEND_W - 1));
         if (go) begin
            running_ff <= 1'b1;
            cnt_ff <= 6'd0;
         end else if (running_ff) begin
            cnt_ff <= cnt_ff + 6'd1;
            if (cnt_ff == 6'(DIVIDEND_W - 1)) begin
               running_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (go) begin
         rem_ff <= '0;
         q_ff <= dividend;
         dsr_ff <= divisor;
      end else if (running_ff) begin
         rem_ff <= take ? DIVISOR_W'(shifted - {1'b0, dsr_ff}) : shifted[DIVISOR_W-1:0];
         q_ff <= {q_ff[DIVIDEND_W-2:0], take};
      end
   end

endmodule

// ----- hw/rtl/gdr_back.sv -----
// Back end: map store, ray set-up, DDA walk and slice results.
module gdr_back #(
   parameter int MAP_DIM = 32,
   parameter int SCREEN_WIDTH = 1024,
   parameter int SCREEN_HEIGHT = 512,
   parameter int TEX_SIZE = 64,
   parameter int ATLAS_COLS = 4
) (
   input  logic clock,
   input  logic reset,
   input  gdr_pkg::head_type head,
   output logic pop,
   input  gdr_pkg::cfg_type cfg,
   output logic rsp_strobe,
   output logic [9:0] rsp_result_column,
   output logic rsp_hit,
   output logic [3:0] rsp_tile,
   output logic rsp_side,
   output logic [23:0] rsp_perp_dist,
   output logic signed [15:0] rsp_draw_start,
   output logic signed [15:0] rsp_draw_end,
   output logic [5:0] rsp_tex_x,
   output logic [11:0] rsp_tex_base_x,
   output logic [11:0] rsp_tex_base_y
);
   import gdr_pkg::*;

   localparam int CELLS = MAP_DIM * MAP_DIM;
   localparam int AW = $clog2(CELLS);
   localparam int MXW = (($clog2(MAP_DIM) > 5) ? $clog2(MAP_DIM) : 5) + 2;
   localparam int HALF = SCREEN_HEIGHT / 2;
   localparam int CAM_Q = 131072 / SCREEN_WIDTH;
   localparam int CAM_R = 131072 % SCREEN_WIDTH;
   localparam longint CAM_M = ((longint'(1) <<< 34) + longint'(SCREEN_WIDTH - 1))
                              / longint'(SCREEN_WIDTH);
   localparam logic [30:0] CAM_M_BITS = 31'(CAM_M);

   state_type state_ff, state_in;
   logic [3:0] map_mem [CELLS];
   logic [3:0] rd_ff;
   logic [AW-1:0] rd_addr, wr_addr;
   logic wr_en;

   logic [9:0] col_ff;
   logic [23:0] camq_ff;
   logic [21:0] camr_ff;
   logic [52:0] cam_prod;
   logic [9:0] cam_frac;
   logic signed [24:0] cam_ff;
   logic signed [25:0] rx_ff, ry_ff;
   logic [23:0] dx_ff, dy_ff, perp_ff;
   logic [35:0] sdx_ff, sdy_ff;
   logic signed [MXW-1:0] mx_ff, my_ff;
   logic side_ff, hit_ff;
   logic [3:0] tile_ff;
   logic [15:0] wall_ff, ds_ff, de_ff;
   logic signed [53:0] prod_ff;
   logic signed [26:0] mul_a, mul_b;

   logic div_go, div_done;
   logic [DIVIDEND_W-1:0] div_dividend, div_q;
   logic [DIVISOR_W-1:0] div_divisor;

   logic [16:0] frac_x, frac_y, lh;
   logic signed [27:0] num;
   logic out_of_map;
   logic [8:0] tex_raw, tex_adj;
   logic [11:0] base_x, base_y;
   logic [3:0] tile_m1;

   gdr_div u_div (
      .clock(clock), .reset(reset), .go(div_go), .dividend(div_dividend),
      .divisor(div_divisor), .done(div_done), .quotient(div_q)
   );

   assign cam_prod = 53'(camr_ff) * 53'(CAM_M_BITS);
   assign cam_frac = cam_prod[43:34];
   assign frac_x = rx_ff[25] ? {1'b0, cfg.pos_x[15:0]} : 17'h10000 - {1'b0, cfg.pos_x[15:0]};
   assign frac_y = ry_ff[25] ? {1'b0, cfg.pos_y[15:0]} : 17'h10000 - {1'b0, cfg.pos_y[15:0]};
   assign out_of_map = (mx_ff < 0) || (my_ff < 0) || (mx_ff >= MAP_DIM) || (my_ff >= MAP_DIM);
   assign rd_addr = AW'(32'(unsigned'(my_ff)) * MAP_DIM + 32'(unsigned'(mx_ff)));
   assign wr_addr = AW'(32'(head.item.cell_y) * MAP_DIM + 32'(head.item.cell_x));
   assign wr_en = (state_ff == S_IDLE) && head.valid && (head.item.operation == OP_WRITE)
                  && (32'(head.item.cell_x) < MAP_DIM) && (32'(head.item.cell_y) < MAP_DIM);
   assign lh = (div_q > 48'(LH_CAP)) ? LH_CAP : div_q[16:0];
   assign tex_raw = prod_ff[24:16];
   assign tex_adj = ((!side_ff && (rx_ff <= 0)) || (side_ff && (ry_ff >= 0)))
                    ? 9'(TEX_SIZE - 1) - tex_raw : tex_raw;
   assign tile_m1 = tile_ff - 4'd1;

   always_comb begin
      if (!side_ff) begin
         num = 28'(mx_ff) * 28'sd65536 - 28'(signed'({1'b0, cfg.pos_x}))
               + (rx_ff[25] ? 28'sd65536 : 28'sd0);
      end else begin
         num = 28'(my_ff) * 28'sd65536 - 28'(signed'({1'b0, cfg.pos_y}))
               + (ry_ff[25] ? 28'sd65536 : 28'sd0);
      end
   end

   always_comb begin
      base_x = '0;
      base_y = '0;
      for (int k = 0; k < 16; k++) begin
         if (tile_m1 == 4'(k)) begin
            base_x = 12'((k % ATLAS_COLS) * TEX_SIZE);
            base_y = 12'((k / ATLAS_COLS) * TEX_SIZE);
         end
      end
   end

   always_comb begin
      div_go = 1'b0;
      div_dividend = '0;
      div_divisor = '0;
      case (state_ff)
         S_DXS: begin
            div_go = 1'b1;
            div_dividend = DIVIDEND_W'(1) << 32;
            div_divisor = abs26(rx_ff);
         end
         S_DYS: begin
            div_go = 1'b1;
            div_dividend = DIVIDEND_W'(1) << 32;
            div_divisor = abs26(ry_ff);
         end
         S_PRS: begin
            div_go = 1'b1;
            div_dividend = DIVIDEND_W'(num[27] ? 28'(-num) : num) << 16;
            div_divisor = abs26(side_ff ? ry_ff : rx_ff);
         end
         S_LHS: begin
            div_go = 1'b1;
            div_dividend = DIVIDEND_W'(SCREEN_HEIGHT) << 16;
            div_divisor = DIVISOR_W'(perp_ff);
         end
         default: begin
            div_go = 1'b0;
         end
      endcase
   end

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_MRX: begin
            mul_a = 27'(cfg.plane_x);
            mul_b = 27'(cam_ff);
         end
         S_MRY: begin
            mul_a = 27'(cfg.plane_y);
            mul_b = 27'(cam_ff);
         end
         S_FX: begin
            mul_a = 27'(signed'({1'b0, frac_x}));
            mul_b = 27'(signed'({1'b0, dx_ff}));
         end
         S_FY: begin
            mul_a = 27'(signed'({1'b0, frac_y}));
            mul_b = 27'(signed'({1'b0, dy_ff}));
         end
         S_LHW: begin
            mul_a = 27'(signed'({1'b0, perp_ff}));
            mul_b = 27'(side_ff ? rx_ff : ry_ff);
         end
         S_TEX1: begin
            mul_a = 27'(signed'({1'b0, wall_ff}));
            mul_b = 27'(TEX_SIZE);
         end
         default: begin
            mul_a = '0;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (head.valid && (head.item.operation == OP_CAST)) begin
               state_in = S_CAMS;
            end
         end
         S_CAMS: state_in = S_CAMW;
         S_CAMW: state_in = S_MRX;
         S_MRX: state_in = S_MRY;
         S_MRY: state_in = S_RY;
         S_RY: state_in = S_DXS;
         S_DXS: state_in = S_DXW;
         S_DXW: if (div_done) state_in = S_DYS;
         S_DYS: state_in = S_DYW;
         S_DYW: if (div_done) state_in = S_FX;
         S_FX: state_in = S_FY;
         S_FY: state_in = S_FYW;
         S_FYW: state_in = S_STEP;
         S_STEP: state_in = S_CHK;
         S_CHK: state_in = out_of_map ? S_PRS : S_TEST;
         S_TEST: state_in = (rd_ff != 4'd0) ? S_PRS : S_STEP;
         S_PRS: state_in = S_PRW;
         S_PRW: if (div_done) state_in = S_LHS;
         S_LHS: state_in = S_LHW;
         S_LHW: if (div_done) state_in = S_TEX1;
         S_TEX1: state_in = S_TEX2;
         S_TEX2: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      pop = (state_ff == S_IDLE) && head.valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_strobe <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_strobe <= (state_ff == S_TEX2);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         map_mem[wr_addr] <= head.item.cell_value;
      end
      rd_ff <= map_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      case (state_ff)
         S_IDLE: begin
            col_ff <= head.item.screen_column;
            hit_ff <= 1'b0;
            tile_ff <= 4'd0;
         end
         S_CAMS: begin
            camq_ff <= 24'(int'(col_ff) * CAM_Q);
            camr_ff <= 22'(int'(col_ff) * CAM_R);
         end
         S_CAMW: cam_ff <= signed'(25'(camq_ff) + 25'(cam_frac)) - 25'sd65536;
         S_MRY: rx_ff <= 26'(cfg.dir_x) + prod_ff[41:16];
         S_RY: ry_ff <= 26'(cfg.dir_y) + prod_ff[41:16];
         S_DXW: dx_ff <= sat24(div_q);
         S_DYW: dy_ff <= sat24(div_q);
         S_FX: begin
            mx_ff <= MXW'(cfg.pos_x[20:16]);
            my_ff <= MXW'(cfg.pos_y[20:16]);
         end
         S_FY: sdx_ff <= 36'(prod_ff[53:16]);
         S_FYW: sdy_ff <= 36'(prod_ff[53:16]);
         S_STEP: begin
            if (sdx_ff < sdy_ff) begin
               sdx_ff <= sdx_ff + 36'(dx_ff);
               mx_ff <= rx_ff[25] ? mx_ff - MXW'(1) : mx_ff + MXW'(1);
               side_ff <= 1'b0;
            end else begin
               sdy_ff <= sdy_ff + 36'(dy_ff);
               my_ff <= ry_ff[25] ? my_ff - MXW'(1) : my_ff + MXW'(1);
               side_ff <= 1'b1;
            end
         end
         S_TEST: begin
            if (rd_ff != 4'd0) begin
               hit_ff <= 1'b1;
               tile_ff <= rd_ff;
            end
         end
         S_PRW: perp_ff <= sat24(div_q);
         S_LHW: begin
            ds_ff <= clamp16(19'(HALF) - 19'({1'b0, lh[16:1]}));
            de_ff <= clamp16(19'(HALF) + 19'({1'b0, lh[16:1]}));
            wall_ff <= (side_ff ? cfg.pos_x[15:0] : cfg.pos_y[15:0]) + prod_ff[31:16];
         end
         S_TEX2: begin
            rsp_result_column <= col_ff;
            rsp_hit <= hit_ff;
            rsp_tile <= tile_ff;
            rsp_side <= side_ff;
            rsp_perp_dist <= perp_ff;
            rsp_draw_start <= ds_ff;
            rsp_draw_end <= de_ff;
            rsp_tex_x <= tex_adj[5:0];
            rsp_tex_base_x <= hit_ff ? base_x : 12'd0;
            rsp_tex_base_y <= hit_ff ? base_y : 12'd0;
         end
         default: begin
            col_ff <= col_ff;
         end
      endcase
   end

endmodule
